### rtl/angular_sector_mask_top_defines.svh
// assertion macros shared by the angular sector mask rtl
`ifndef ANGULAR_SECTOR_MASK_TOP_DEFINES_SVH
`define ANGULAR_SECTOR_MASK_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// checked at every rising edge outside reset
`define ASM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every rising edge, reset included
`define ASM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASM_ASSERT(lbl, clk, rst_n, prop, msg)
`define ASM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/asm_pkg.sv
// types and constants shared by the angular sector mask modules
package asm_pkg;

    // coordinate and register widths
    localparam int COORD_BITS = 12;
    localparam int REG_BITS   = 13;

    // register stages from accept to the mask strobe
    localparam int PIPE_DEPTH = 7;

    // configuration register file
    localparam int CFG_COUNT = 6;
    localparam int CFG_IDX_W = $clog2(CFG_COUNT);

    localparam logic [CFG_IDX_W-1:0] CFG_APEX_X     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_APEX_Y     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_ONE_X = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_ONE_Y = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_TWO_X = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_TWO_Y = CFG_IDX_W'(5);

    // datapath widths
    localparam int VEC_W  = ((COORD_BITS + 1 > REG_BITS) ? COORD_BITS + 1 : REG_BITS) + 1;
    localparam int PROD_W = 2 * VEC_W;
    localparam int NORM_W = 2 * VEC_W - 1;
    localparam int DOT_W  = 2 * VEC_W;
    localparam int MAG_W  = NORM_W;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int PART_W = MAG_W + NORM_W;
    localparam int WIDE_W = SQ_W + NORM_W;

    // mask codes
    localparam logic [7:0] MASK_ON  = 8'd255;
    localparam logic [7:0] MASK_OFF = 8'd0;

    typedef logic signed [REG_BITS-1:0] coord_reg_t;
    typedef logic signed [VEC_W-1:0]    vec_t;
    typedef logic        [NORM_W-1:0]   norm_t;
    typedef logic signed [DOT_W-1:0]    dot_t;
    typedef logic        [WIDE_W-1:0]   wide_t;

    typedef struct packed {
        coord_reg_t apex_x;
        coord_reg_t apex_y;
        coord_reg_t edge_one_x;
        coord_reg_t edge_one_y;
        coord_reg_t edge_two_x;
        coord_reg_t edge_two_y;
    } cfg_t;

    typedef struct packed {
        vec_t vx;
        vec_t vy;
        vec_t e1x;
        vec_t e1y;
        vec_t e2x;
        vec_t e2y;
    } diff_data_t;

    typedef struct packed {
        logic       valid;
        diff_data_t data;
    } diff_beat_t;

    typedef struct packed {
        norm_t n;
        norm_t n1;
        norm_t n2;
        dot_t  d1;
        dot_t  d2;
        dot_t  d12;
    } dot_data_t;

    typedef struct packed {
        logic      valid;
        dot_data_t data;
    } dot_beat_t;

    typedef struct packed {
        logic  no_area;
        logic  d1_neg;
        logic  d2_neg;
        logic  d12_neg;
        wide_t lhs1;
        wide_t lhs2;
        wide_t rhs;
    } scale_data_t;

    typedef struct packed {
        logic        valid;
        scale_data_t data;
    } scale_beat_t;

endpackage

### rtl/asm_diff.sv
// first stage: pixel and edge vectors relative to the apex
module asm_diff
    import asm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] pixel_x,
    input  logic [COORD_BITS-1:0] pixel_y,
    input  cfg_t                  cfg,
    output diff_beat_t            beat
);

    logic       valid_reg;
    diff_data_t data_reg;
    diff_data_t data_next;

    always_comb
    begin
        data_next.vx  = vec_t'({1'b0, pixel_x}) - vec_t'(cfg.apex_x);
        data_next.vy  = vec_t'({1'b0, pixel_y}) - vec_t'(cfg.apex_y);
        data_next.e1x = vec_t'(cfg.edge_one_x) - vec_t'(cfg.apex_x);
        data_next.e1y = vec_t'(cfg.edge_one_y) - vec_t'(cfg.apex_y);
        data_next.e2x = vec_t'(cfg.edge_two_x) - vec_t'(cfg.apex_x);
        data_next.e2y = vec_t'(cfg.edge_two_y) - vec_t'(cfg.apex_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            data_reg <= data_next;
        end
    end

    assign beat = '{valid: valid_reg, data: data_reg};

endmodule

### rtl/asm_dot.sv
// two stages: squares and dot products, then norms and dot sums
module asm_dot
    import asm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  diff_beat_t in_beat,
    output dot_beat_t  beat
);

    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        prod_t vxx;
        prod_t vyy;
        prod_t e1xx;
        prod_t e1yy;
        prod_t e2xx;
        prod_t e2yy;
        prod_t e1x_vx;
        prod_t e1y_vy;
        prod_t e2x_vx;
        prod_t e2y_vy;
        prod_t e1x_e2x;
        prod_t e1y_e2y;
    } prod_set_t;

    logic      prod_valid_reg;
    prod_set_t prod_reg;
    prod_set_t prod_next;
    logic      sum_valid_reg;
    dot_data_t sum_reg;
    dot_data_t sum_next;
    prod_t     n_sum;
    prod_t     n1_sum;
    prod_t     n2_sum;

    function automatic prod_t smul(input vec_t a, input vec_t b);
        smul = PROD_W'(a) * PROD_W'(b);
    endfunction

    // products, one multiplier deep
    always_comb
    begin
        prod_next.vxx     = smul(in_beat.data.vx, in_beat.data.vx);
        prod_next.vyy     = smul(in_beat.data.vy, in_beat.data.vy);
        prod_next.e1xx    = smul(in_beat.data.e1x, in_beat.data.e1x);
        prod_next.e1yy    = smul(in_beat.data.e1y, in_beat.data.e1y);
        prod_next.e2xx    = smul(in_beat.data.e2x, in_beat.data.e2x);
        prod_next.e2yy    = smul(in_beat.data.e2y, in_beat.data.e2y);
        prod_next.e1x_vx  = smul(in_beat.data.e1x, in_beat.data.vx);
        prod_next.e1y_vy  = smul(in_beat.data.e1y, in_beat.data.vy);
        prod_next.e2x_vx  = smul(in_beat.data.e2x, in_beat.data.vx);
        prod_next.e2y_vy  = smul(in_beat.data.e2y, in_beat.data.vy);
        prod_next.e1x_e2x = smul(in_beat.data.e1x, in_beat.data.e2x);
        prod_next.e1y_e2y = smul(in_beat.data.e1y, in_beat.data.e2y);
    end

    // norms are non-negative and fit one bit less than a product
    always_comb
    begin
        n_sum        = prod_reg.vxx + prod_reg.vyy;
        n1_sum       = prod_reg.e1xx + prod_reg.e1yy;
        n2_sum       = prod_reg.e2xx + prod_reg.e2yy;
        sum_next.n   = n_sum[NORM_W-1:0];
        sum_next.n1  = n1_sum[NORM_W-1:0];
        sum_next.n2  = n2_sum[NORM_W-1:0];
        sum_next.d1  = DOT_W'(prod_reg.e1x_vx + prod_reg.e1y_vy);
        sum_next.d2  = DOT_W'(prod_reg.e2x_vx + prod_reg.e2y_vy);
        sum_next.d12 = DOT_W'(prod_reg.e1x_e2x + prod_reg.e1y_e2y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_beat.valid;
            sum_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat.valid)
        begin
            prod_reg <= prod_next;
        end
        if (prod_valid_reg)
        begin
            sum_reg <= sum_next;
        end
    end

    assign beat = '{valid: sum_valid_reg, data: sum_reg};

endmodule

### rtl/asm_scale.sv
// three stages: squared dots, split partial products, wide recombine
module asm_scale
    import asm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dot_beat_t   in_beat,
    output scale_beat_t beat
);

    typedef logic [SQ_W-1:0]   sq_t;
    typedef logic [PART_W-1:0] part_t;

    typedef struct packed {
        logic  no_area;
        logic  d1_neg;
        logic  d2_neg;
        logic  d12_neg;
        sq_t   sq1;
        sq_t   sq2;
        sq_t   sq12;
        norm_t n;
        norm_t n1;
        norm_t n2;
    } sq_data_t;

    typedef struct packed {
        logic  no_area;
        logic  d1_neg;
        logic  d2_neg;
        logic  d12_neg;
        part_t l1_lo;
        part_t l1_hi;
        part_t l2_lo;
        part_t l2_hi;
        part_t r_lo;
        part_t r_hi;
    } part_data_t;

    logic        sq_valid_reg;
    sq_data_t    sq_reg;
    sq_data_t    sq_next;
    logic        part_valid_reg;
    part_data_t  part_reg;
    part_data_t  part_next;
    logic        wide_valid_reg;
    scale_data_t wide_reg;
    scale_data_t wide_next;

    function automatic logic [MAG_W-1:0] dot_mag(input dot_t d);
        dot_t m;
        m = d[DOT_W-1] ? -d : d;
        dot_mag = m[MAG_W-1:0];
    endfunction

    function automatic sq_t square(input logic [MAG_W-1:0] m);
        square = SQ_W'(m) * SQ_W'(m);
    endfunction

    function automatic part_t pmul(input logic [MAG_W-1:0] a, input norm_t b);
        pmul = PART_W'(a) * PART_W'(b);
    endfunction

    function automatic wide_t join_parts(input part_t lo, input part_t hi);
        join_parts = (WIDE_W'(hi) << MAG_W) + WIDE_W'(lo);
    endfunction

    // squared magnitudes of the dots plus the early reject
    always_comb
    begin
        sq_next.no_area = (in_beat.data.n1 == '0) || (in_beat.data.n2 == '0)
                       || (in_beat.data.n == '0)
                       || ((in_beat.data.n > in_beat.data.n1)
                           && (in_beat.data.n > in_beat.data.n2));
        sq_next.d1_neg  = in_beat.data.d1[DOT_W-1];
        sq_next.d2_neg  = in_beat.data.d2[DOT_W-1];
        sq_next.d12_neg = in_beat.data.d12[DOT_W-1];
        sq_next.sq1     = square(dot_mag(in_beat.data.d1));
        sq_next.sq2     = square(dot_mag(in_beat.data.d2));
        sq_next.sq12    = square(dot_mag(in_beat.data.d12));
        sq_next.n       = in_beat.data.n;
        sq_next.n1      = in_beat.data.n1;
        sq_next.n2      = in_beat.data.n2;
    end

    // squared dot times norm, split in two halves
    always_comb
    begin
        part_next.no_area = sq_reg.no_area;
        part_next.d1_neg  = sq_reg.d1_neg;
        part_next.d2_neg  = sq_reg.d2_neg;
        part_next.d12_neg = sq_reg.d12_neg;
        part_next.l1_lo   = pmul(sq_reg.sq1[MAG_W-1:0], sq_reg.n2);
        part_next.l1_hi   = pmul(sq_reg.sq1[SQ_W-1:MAG_W], sq_reg.n2);
        part_next.l2_lo   = pmul(sq_reg.sq2[MAG_W-1:0], sq_reg.n1);
        part_next.l2_hi   = pmul(sq_reg.sq2[SQ_W-1:MAG_W], sq_reg.n1);
        part_next.r_lo    = pmul(sq_reg.sq12[MAG_W-1:0], sq_reg.n);
        part_next.r_hi    = pmul(sq_reg.sq12[SQ_W-1:MAG_W], sq_reg.n);
    end

    always_comb
    begin
        wide_next.no_area = part_reg.no_area;
        wide_next.d1_neg  = part_reg.d1_neg;
        wide_next.d2_neg  = part_reg.d2_neg;
        wide_next.d12_neg = part_reg.d12_neg;
        wide_next.lhs1    = join_parts(part_reg.l1_lo, part_reg.l1_hi);
        wide_next.lhs2    = join_parts(part_reg.l2_lo, part_reg.l2_hi);
        wide_next.rhs     = join_parts(part_reg.r_lo, part_reg.r_hi);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg   <= 1'b0;
            part_valid_reg <= 1'b0;
            wide_valid_reg <= 1'b0;
        end
        else
        begin
            sq_valid_reg   <= in_beat.valid;
            part_valid_reg <= sq_valid_reg;
            wide_valid_reg <= part_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat.valid)
        begin
            sq_reg <= sq_next;
        end
        if (sq_valid_reg)
        begin
            part_reg <= part_next;
        end
        if (part_valid_reg)
        begin
            wide_reg <= wide_next;
        end
    end

    assign beat = '{valid: wide_valid_reg, data: wide_reg};

endmodule

### rtl/asm_decide.sv
// last stage: sign-aware cosine compares and the mask output register
`include "angular_sector_mask_top_defines.svh"
module asm_decide
    import asm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  scale_beat_t in_beat,
    output logic        done,
    output logic [7:0]  mask_value
);

    logic       done_reg;
    logic [7:0] mask_reg;
    logic [7:0] mask_next;
    logic       ge1;
    logic       ge2;

    // a*sqrt(p) >= b*sqrt(q), with lhs = a^2 p and rhs = b^2 q
    function automatic logic scaled_ge(input logic a_neg, input logic b_neg,
                                       input wide_t lhs, input wide_t rhs);
        logic result;
        if (!a_neg && b_neg)
        begin
            result = 1'b1;
        end
        else if (a_neg && !b_neg)
        begin
            result = 1'b0;
        end
        else if (!a_neg)
        begin
            result = (lhs >= rhs);
        end
        else
        begin
            result = (lhs <= rhs);
        end
        scaled_ge = result;
    endfunction

    always_comb
    begin
        ge1 = scaled_ge(in_beat.data.d1_neg, in_beat.data.d12_neg,
                        in_beat.data.lhs1, in_beat.data.rhs);
        ge2 = scaled_ge(in_beat.data.d2_neg, in_beat.data.d12_neg,
                        in_beat.data.lhs2, in_beat.data.rhs);
        mask_next = (!in_beat.data.no_area && ge1 && ge2) ? MASK_ON : MASK_OFF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_beat.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat.valid)
        begin
            mask_reg <= mask_next;
        end
    end

    assign done       = done_reg;
    assign mask_value = mask_reg;

    `ASM_ASSERT(a_no_area_off, clk, rst_n, in_beat.valid && in_beat.data.no_area |=> mask_value == MASK_OFF, "rejected pixel gave a nonzero mask")
    `ASM_ASSERT(a_opposite_sign_off, clk, rst_n, in_beat.valid && in_beat.data.d1_neg && !in_beat.data.d12_neg |=> mask_value == MASK_OFF, "pixel behind first edge gave a nonzero mask")

endmodule

### rtl/angular_sector_mask_top.sv
// top level of the angular sector mask: config registers and the staged pipeline
//
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------------
//  pixel in  | start, busy          | pixel_x, pixel_y (COORD_BITS, unsigned)
//  mask out  | done (strobe)        | mask_value (8 bits, 255 or 0)
//  config    | cfg_write            | cfg_index (3 bits), cfg_data (13 bits)
//
//  one pixel beat per cycle; busy is always low since nothing ever stalls
//  a beat accepted at one edge has its mask on the output once it has passed
//  the diff, dot, scale and decide registers, with done high for one cycle
//  the stages in datapath order: vector subtract, squares and dots,
//  dot sums, squared dots, split partial products, wide recombine, compare
//  rst_n clears the config registers to zero and all stage valid bits
//  the receiver cannot stall, so results are never held back or dropped
`include "angular_sector_mask_top_defines.svh"
module angular_sector_mask_top
    import asm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] pixel_x,
    input  logic [COORD_BITS-1:0] pixel_y,
    output logic                  done,
    output logic [7:0]            mask_value,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [REG_BITS-1:0]   cfg_data
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    diff_beat_t  diff_beat;
    dot_beat_t   dot_beat;
    scale_beat_t scale_beat;

    // the pipeline takes a beat every cycle
    assign busy = 1'b0;

    // config register file, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_APEX_X:     cfg_next.apex_x     = coord_reg_t'(cfg_data);
                CFG_APEX_Y:     cfg_next.apex_y     = coord_reg_t'(cfg_data);
                CFG_EDGE_ONE_X: cfg_next.edge_one_x = coord_reg_t'(cfg_data);
                CFG_EDGE_ONE_Y: cfg_next.edge_one_y = coord_reg_t'(cfg_data);
                CFG_EDGE_TWO_X: cfg_next.edge_two_x = coord_reg_t'(cfg_data);
                CFG_EDGE_TWO_Y: cfg_next.edge_two_y = coord_reg_t'(cfg_data);
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // stage 1: vectors from the apex
    asm_diff u_diff
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start && !busy),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y),
        .cfg     (cfg_reg),
        .beat    (diff_beat)
    );

    // stages 2 and 3: products, then norms and dots
    asm_dot u_dot
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_beat (diff_beat),
        .beat    (dot_beat)
    );

    // stages 4 to 6: squared dots scaled by the opposite norms
    asm_scale u_scale
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_beat (dot_beat),
        .beat    (scale_beat)
    );

    // stage 7: compares and the output register
    asm_decide u_decide
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_beat    (scale_beat),
        .done       (done),
        .mask_value (mask_value)
    );

    `ASM_ASSERT(a_start_gives_done, clk, rst_n, start |-> ##PIPE_DEPTH done, "accepted pixel beat lost in the pipeline")
    `ASM_ASSERT(a_no_spurious_done, clk, rst_n, !start |-> ##PIPE_DEPTH !done, "mask strobe without an accepted pixel beat")
    `ASM_ASSERT_ALWAYS(a_quiet_in_reset, clk, !rst_n |=> !done, "mask strobe after a reset cycle")

endmodule
